FILE: rtl/crlb_pkg.sv
// ============================================================================
// crlb_pkg: shared types and constants
// Sizes, codes and the sequencer state type of the convolution block.
// ============================================================================
`default_nettype none

package crlb_pkg;

    localparam int IMAGE_HEIGHT = 32;
    localparam int IMAGE_WIDTH  = 32;
    localparam int KERNEL_SIZE  = 4;
    localparam int FILTER_COUNT = 8;

    localparam int LINE_ROWS  = KERNEL_SIZE - 1;
    localparam int WIN_DEPTH  = KERNEL_SIZE * KERNEL_SIZE;
    localparam int WGT_DEPTH  = FILTER_COUNT * WIN_DEPTH;
    localparam int POS_W      = 5;
    localparam int TAP_W      = 4;
    localparam int FILT_W     = 3;
    localparam int KIDX_W     = 2;
    localparam int DATA_W     = 16;
    localparam int ACC_W      = 40;
    localparam int ACT_W      = 15;
    localparam int FRAC_SHIFT = 14;

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_BIAS,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic first;
        logic acc_en;
    } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/conv2d_relu_line_buffer_core.sv
// ============================================================================
// conv2d_relu_line_buffer_core: 4x4 convolution, bias and ReLU over a stream
// Line buffer in RAM, window in registers, one shared MAC for all filters.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | op, sample, kernel_row, kernel_col,
//          |                      | filter_select, frame_start
//  out     | out_valid / out_ready| out_row, out_col, filter_id, activation, last
//
//  A load item is written in idle and leaves the block idle. A pixel that
//  closes no window passes the shift state back to idle; one that closes a
//  window runs each filter through the single MAC: a bias read, one
//  accumulate per window tap, then one result item that waits for out_ready.
//  in_ready is high only in idle. Reset clears counters, window and sequencer;
//  weight, bias and line RAMs hold nothing defined until written.
// ============================================================================
`default_nettype none

module conv2d_relu_line_buffer_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           op,
    input  wire logic signed [crlb_pkg::DATA_W-1:0]   sample,
    input  wire logic [crlb_pkg::KIDX_W-1:0]          kernel_row,
    input  wire logic [crlb_pkg::KIDX_W-1:0]          kernel_col,
    input  wire logic [crlb_pkg::FILT_W-1:0]          filter_select,
    input  wire logic                                 frame_start,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [crlb_pkg::POS_W-1:0]                out_row,
    output logic [crlb_pkg::POS_W-1:0]                out_col,
    output logic [crlb_pkg::FILT_W-1:0]               filter_id,
    output logic [crlb_pkg::ACT_W-1:0]                activation,
    output logic                                      last
);
    import crlb_pkg::*;

    state_t state_reg, state_next;

    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [FILT_W-1:0] filt_reg, filt_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic signed [DATA_W-1:0] pix_reg;
    logic signed [DATA_W-1:0] win_reg [WIN_DEPTH];

    logic in_acc;
    logic pix_acc;
    logic [POS_W-1:0] cur_col;
    logic win_done;
    logic advance;

    logic signed [DATA_W-1:0] colv [KERNEL_SIZE];
    logic signed [DATA_W-1:0] wgt_rdata;
    logic signed [DATA_W-1:0] bias_rdata;

    logic                  wgt_re;
    logic [TAP_W+FILT_W-1:0] wgt_raddr;
    logic                  bias_re;
    logic                  line_we;
    mac_ctrl_t             mac_ctrl;

    assign in_acc   = in_valid && in_ready;
    assign pix_acc  = in_acc && (op_t'(op) == OP_PIXEL);
    assign cur_col  = frame_start ? '0 : col_reg;
    assign win_done = (row_reg >= POS_W'(KERNEL_SIZE - 1)) &&
                      (col_reg >= POS_W'(KERNEL_SIZE - 1));

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    crlb_ram #(.WIDTH(DATA_W), .DEPTH(WGT_DEPTH)) u_wgt_ram (
        .clk   (clk),
        .we    (in_acc && (op_t'(op) == OP_WEIGHT)),
        .waddr ({filter_select, kernel_row, kernel_col}),
        .wdata (sample),
        .re    (wgt_re),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

    crlb_ram #(.WIDTH(DATA_W), .DEPTH(FILTER_COUNT)) u_bias_ram (
        .clk   (clk),
        .we    (in_acc && (op_t'(op) == OP_BIAS)),
        .waddr (filter_select),
        .wdata (sample),
        .re    (bias_re),
        .raddr (filt_reg),
        .rdata (bias_rdata)
    );

    // Each buffered row has its own RAM, so a whole column is read at once.
    for (genvar k = 0; k < LINE_ROWS; k++)
    begin : g_line
        crlb_ram #(.WIDTH(DATA_W), .DEPTH(IMAGE_WIDTH)) u_line_ram (
            .clk   (clk),
            .we    (line_we),
            .waddr (col_reg),
            .wdata (colv[k+1]),
            .re    (pix_acc),
            .raddr (cur_col),
            .rdata (colv[k])
        );
    end
    assign colv[KERNEL_SIZE-1] = pix_reg;

    // ------------------------------------------------------------------
    // Shared MAC
    // ------------------------------------------------------------------
    crlb_mac u_mac (
        .clk        (clk),
        .ctrl       (mac_ctrl),
        .bias       (bias_rdata),
        .weight     (wgt_rdata),
        .pixel      (win_reg[tap_reg]),
        .activation (activation)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_acc)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                state_next = win_done ? ST_BIAS : ST_IDLE;
            end
            ST_BIAS:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (tap_reg == TAP_W'(WIN_DEPTH - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = (filt_reg == FILT_W'(FILTER_COUNT - 1)) ? ST_IDLE : ST_BIAS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and counters
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        line_we         = 1'b0;
        wgt_re          = 1'b0;
        wgt_raddr       = {filt_reg, tap_reg};
        bias_re         = 1'b0;
        mac_ctrl.first  = 1'b0;
        mac_ctrl.acc_en = 1'b0;
        advance         = 1'b0;
        filt_next       = filt_reg;
        tap_next        = tap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SHIFT:
            begin
                line_we   = 1'b1;
                advance   = !win_done;
                filt_next = '0;
            end
            ST_BIAS:
            begin
                bias_re   = 1'b1;
                wgt_re    = 1'b1;
                wgt_raddr = {filt_reg, TAP_W'(0)};
                tap_next  = '0;
            end
            ST_ACC:
            begin
                mac_ctrl.first  = (tap_reg == '0);
                mac_ctrl.acc_en = 1'b1;
                wgt_re          = 1'b1;
                wgt_raddr       = {filt_reg, tap_reg + TAP_W'(1)};
                tap_next        = tap_reg + TAP_W'(1);
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    filt_next = filt_reg + FILT_W'(1);
                    advance   = (filt_reg == FILT_W'(FILTER_COUNT - 1));
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (pix_acc && frame_start)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (advance)
        begin
            if (col_reg == POS_W'(IMAGE_WIDTH - 1))
            begin
                col_next = '0;
                row_next = (row_reg == POS_W'(IMAGE_HEIGHT - 1)) ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    assign out_row   = row_reg - POS_W'(KERNEL_SIZE - 1);
    assign out_col   = col_reg - POS_W'(KERNEL_SIZE - 1);
    assign filter_id = filt_reg;
    assign last      = (filt_reg == FILT_W'(FILTER_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            filt_reg  <= '0;
            tap_reg   <= '0;
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            filt_reg  <= filt_next;
            tap_reg   <= tap_next;
            if (state_reg == ST_SHIFT)
            begin
                for (int r = 0; r < KERNEL_SIZE; r++)
                begin
                    for (int c = 0; c < KERNEL_SIZE - 1; c++)
                    begin
                        win_reg[r*KERNEL_SIZE+c] <= win_reg[r*KERNEL_SIZE+c+1];
                    end
                    win_reg[r*KERNEL_SIZE+KERNEL_SIZE-1] <= colv[r];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            pix_reg <= sample;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |=> !in_ready)
        else $error("in_ready high right after a pixel item");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("block not idle after the last result of a window");

    a_result_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> win_done)
        else $error("result item without a complete window");
`endif

endmodule

`default_nettype wire

FILE: rtl/crlb_ram.sv
// ============================================================================
// crlb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module crlb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crlb_mac.sv
// ============================================================================
// crlb_mac: shared multiply-accumulate unit
// One product per enabled cycle into a 40-bit accumulator, ReLU, saturation.
// ============================================================================
`default_nettype none

module crlb_mac (
    input  wire logic                                  clk,
    input  wire crlb_pkg::mac_ctrl_t                   ctrl,
    input  wire logic signed [crlb_pkg::DATA_W-1:0]    bias,
    input  wire logic signed [crlb_pkg::DATA_W-1:0]    weight,
    input  wire logic signed [crlb_pkg::DATA_W-1:0]    pixel,
    output logic             [crlb_pkg::ACT_W-1:0]     activation
);
    import crlb_pkg::*;

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    base;
    logic signed [2*DATA_W-1:0] prod;
    logic signed [ACC_W-FRAC_SHIFT-1:0] scaled;

    assign prod = weight * pixel;

    always_comb
    begin
        base     = ctrl.first ? (ACC_W'(bias) <<< FRAC_SHIFT) : acc_reg;
        acc_next = base + ACC_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // The sum is positive where the shift is taken, so truncation is a floor.
    always_comb
    begin
        scaled = acc_reg[ACC_W-1:FRAC_SHIFT];
        if (acc_reg <= 0)
        begin
            activation = '0;
        end
        else if (scaled > (ACC_W-FRAC_SHIFT)'(32767))
        begin
            activation = '1;
        end
        else
        begin
            activation = scaled[ACT_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: sim/conv2d_relu_line_buffer_core_test.sv
// ============================================================================
// conv2d_relu_line_buffer_core_test: stream test of the 4x4 convolution block
// Loads weights and biases, streams the first rows of a frame up to complete
// windows, drains, then finishes the row, checking every activation against
// a local predictor.
// ============================================================================

module conv2d_relu_line_buffer_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import crlb_pkg::*;

    typedef struct {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [FILT_W-1:0] filt;
        logic [ACT_W-1:0]  act;
        logic              lst;
    } activation_t;

    class activation_scoreboard;
        logic signed [DATA_W-1:0] line_mem[LINE_ROWS*IMAGE_WIDTH];
        logic signed [DATA_W-1:0] win[WIN_DEPTH];
        logic signed [DATA_W-1:0] wgt[WGT_DEPTH];
        logic signed [DATA_W-1:0] bias[FILTER_COUNT];
        int                       prow;
        int                       pcol;
        int                       errors;
        activation_t              pending[$];

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i]) win[i] = '0;
            foreach (wgt[i]) wgt[i] = '0;
            foreach (bias[i]) bias[i] = '0;
            prow = 0;
            pcol = 0;
            errors = 0;
        endfunction

        function void note_input(op_t o, logic signed [DATA_W-1:0] s, logic [1:0] kr,
                                 logic [1:0] kc, logic [2:0] fs, logic fst);
            logic signed [DATA_W-1:0] colv[KERNEL_SIZE];
            longint                   acc;
            activation_t              r;
            case (o)
                OP_WEIGHT: wgt[fs*WIN_DEPTH + kr*KERNEL_SIZE + kc] = s;
                OP_BIAS:   bias[fs] = s;
                OP_PIXEL:
                begin
                    if (fst)
                    begin
                        prow = 0;
                        pcol = 0;
                    end
                    for (int k = 0; k < LINE_ROWS; k++)
                        colv[k] = line_mem[k*IMAGE_WIDTH + pcol];
                    colv[KERNEL_SIZE-1] = s;
                    for (int k = 0; k < LINE_ROWS; k++)
                        line_mem[k*IMAGE_WIDTH + pcol] = colv[k+1];
                    for (int rr = 0; rr < KERNEL_SIZE; rr++)
                    begin
                        for (int cc = 0; cc < KERNEL_SIZE-1; cc++)
                            win[rr*KERNEL_SIZE + cc] = win[rr*KERNEL_SIZE + cc + 1];
                        win[rr*KERNEL_SIZE + KERNEL_SIZE-1] = colv[rr];
                    end
                    if (prow >= KERNEL_SIZE-1 && pcol >= KERNEL_SIZE-1)
                    begin
                        for (int f = 0; f < FILTER_COUNT; f++)
                        begin
                            acc = longint'(bias[f]) * 16384;
                            for (int i = 0; i < WIN_DEPTH; i++)
                                acc += longint'(win[i]) * longint'(wgt[f*WIN_DEPTH + i]);
                            if (acc <= 0)
                                acc = 0;
                            else
                            begin
                                acc = acc >>> FRAC_SHIFT;
                                if (acc > 32767) acc = 32767;
                            end
                            r.row  = POS_W'(prow - (KERNEL_SIZE-1));
                            r.col  = POS_W'(pcol - (KERNEL_SIZE-1));
                            r.filt = FILT_W'(f);
                            r.act  = ACT_W'(acc);
                            r.lst  = (f == FILTER_COUNT-1);
                            pending.push_back(r);
                        end
                    end
                    if (pcol + 1 >= IMAGE_WIDTH)
                    begin
                        pcol = 0;
                        prow = (prow + 1 >= IMAGE_HEIGHT) ? 0 : prow + 1;
                    end
                    else
                        pcol++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(activation_t got);
            activation_t exp_r;
            if (pending.size() == 0)
            begin
                $error("activation item with nothing expected");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.row !== exp_r.row)
            begin
                $error("out_row expected %0d actual %0d", exp_r.row, got.row);
                errors++;
            end
            if (got.col !== exp_r.col)
            begin
                $error("out_col expected %0d actual %0d", exp_r.col, got.col);
                errors++;
            end
            if (got.filt !== exp_r.filt)
            begin
                $error("filter_id expected %0d actual %0d", exp_r.filt, got.filt);
                errors++;
            end
            if (got.act !== exp_r.act)
            begin
                $error("activation expected %0d actual %0d", exp_r.act, got.act);
                errors++;
            end
            if (got.lst !== exp_r.lst)
            begin
                $error("last expected %0d actual %0d", exp_r.lst, got.lst);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               op;
    logic signed [DATA_W-1:0] sample;
    logic [KIDX_W-1:0]        kernel_row;
    logic [KIDX_W-1:0]        kernel_col;
    logic [FILT_W-1:0]        filter_select;
    logic                     frame_start;
    logic                     out_valid;
    logic                     out_ready;
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_col;
    logic [FILT_W-1:0]        filter_id;
    logic [ACT_W-1:0]         activation;
    logic                     last;

    activation_scoreboard sb;
    bit                   quiet;
    int unsigned          cycles;

    conv2d_relu_line_buffer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .sample        (sample),
        .kernel_row    (kernel_row),
        .kernel_col    (kernel_col),
        .filter_select (filter_select),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .filter_id     (filter_id),
        .activation    (activation),
        .last          (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= quiet || ($urandom_range(99) >= 8);
        if (rst_n && out_valid && out_ready)
            sb.check_result('{out_row, out_col, filter_id, activation, last});
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Valid stays high between back-to-back items; it is lowered only for a gap.
    task automatic send_item(op_t o, logic signed [DATA_W-1:0] s, logic [1:0] kr,
                             logic [1:0] kc, logic [2:0] fs, logic fst);
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        sample        <= s;
        kernel_row    <= kr;
        kernel_col    <= kc;
        filter_select <= fs;
        frame_start   <= fst;
        do @(posedge clk); while (!in_ready);
        sb.note_input(o, s, kr, kc, fs, fst);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_pixel();
        if ($urandom_range(7) == 0)
            return DATA_W'($urandom);
        return DATA_W'(int'($urandom_range(1024)) - 512);
    endfunction

    task automatic send_pixels(int count, logic first_flag);
        for (int i = 0; i < count; i++)
        begin
            quiet = (i >= 40 && i < 100);
            if ($urandom_range(24) == 0)
                send_item(op_t'($urandom_range(1) ? OP_NONE : OP_WEIGHT),
                          DATA_W'(int'($urandom_range(8192)) - 4096),
                          KIDX_W'($urandom), KIDX_W'($urandom), FILT_W'($urandom),
                          1'($urandom));
            send_item(OP_PIXEL, rand_pixel(), KIDX_W'($urandom), KIDX_W'($urandom),
                      FILT_W'($urandom), first_flag && i == 0);
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        sb            = new();
        quiet         = 1'b0;
        cycles        = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        op            = OP_NONE;
        sample        = '0;
        kernel_row    = '0;
        kernel_col    = '0;
        filter_select = '0;
        frame_start   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An unused op code with every field set must be ignored.
        send_item(OP_NONE, 16'sh7fff, 2'd3, 2'd3, 3'd7, 1'b1);
        send_item(OP_NONE, -16'sd32768, 2'd0, 2'd0, 3'd0, 1'b0);

        // Filter 0 gets the largest weights and bias, filter 1 the most negative, the rest are mixed.
        for (int f = 0; f < FILTER_COUNT; f++)
            for (int k = 0; k < WIN_DEPTH; k++)
                send_item(OP_WEIGHT,
                          (f == 0) ? 16'sh7fff : (f == 1) ? -16'sd32768 :
                          ($urandom_range(5) == 0) ? DATA_W'($urandom) :
                          DATA_W'(int'($urandom_range(8192)) - 4096),
                          KIDX_W'(k / KERNEL_SIZE), KIDX_W'(k % KERNEL_SIZE),
                          FILT_W'(f), k[0]);
        for (int f = 0; f < FILTER_COUNT; f++)
            send_item(OP_BIAS,
                      (f == 0) ? 16'sh7fff : (f == 1) ? -16'sd32768 :
                      DATA_W'(int'($urandom_range(8192)) - 4096),
                      KIDX_W'($urandom), KIDX_W'($urandom), FILT_W'(f), f[0]);

        // The first rows of a frame, far enough to close windows, then a drain.
        send_pixels(IMAGE_WIDTH * KERNEL_SIZE - 8, 1'b1);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);

        // The rest of the row continues without a frame start.
        send_pixels(8, 1'b0);
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
